// ===== rtl/pfcr_pkg.sv =====
// Package for the proportional font column renderer.
// Holds the beat structs, the font and pattern table, and the character decoder.
// No dependencies.
package pfcr_pkg;

    typedef struct packed {
        logic [7:0] start_column;
        logic [3:0] page_row;
        logic [7:0] char_code;
    } pfcr_in_t;

    typedef struct packed {
        logic [8:0] buffer_address;
        logic [7:0] column_bits;
        logic       write_enable;
        logic [8:0] next_column;
        logic       last_column;
    } pfcr_out_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] start;
        logic [2:0] len;
    } pfcr_dec_t;

    localparam int unsigned GLYPH_W    = 5;
    localparam int unsigned ROM_DEPTH  = 154;
    localparam int unsigned RAM_DEPTH  = 256;
    localparam int unsigned RAM_AW     = 8;

    // Character codes with a fixed pattern or a range boundary
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_PERIOD  = 8'h2E;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_FOLD  = 8'd32;

    // Table addresses of the fixed patterns, stored after the font glyphs
    localparam logic [7:0] ADDR_COLON   = 8'd141;
    localparam logic [7:0] ADDR_PERIOD  = 8'd142;
    localparam logic [7:0] ADDR_SPACE   = 8'd143;
    localparam logic [7:0] ADDR_STAR    = 8'd144;
    localparam logic [7:0] ADDR_PERCENT = 8'd149;

    localparam logic [GLYPH_W-1:0] GLYPH_ROM [0:ROM_DEPTH-1] = '{
        5'h0e, 5'h11, 5'h11, 5'h0e, 5'h12, 5'h1f, 5'h10, 5'h12,
        5'h19, 5'h15, 5'h12, 5'h11, 5'h15, 5'h15, 5'h0a, 5'h0c,
        5'h0a, 5'h09, 5'h1f, 5'h17, 5'h15, 5'h15, 5'h0d, 5'h0e,
        5'h15, 5'h15, 5'h08, 5'h01, 5'h01, 5'h1d, 5'h03, 5'h0a,
        5'h15, 5'h15, 5'h0a, 5'h02, 5'h15, 5'h15, 5'h0e, 5'h1e,
        5'h05, 5'h05, 5'h1e, 5'h1f, 5'h15, 5'h15, 5'h0a, 5'h0e,
        5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h0e, 5'h1f,
        5'h15, 5'h15, 5'h1f, 5'h05, 5'h05, 5'h0e, 5'h11, 5'h15,
        5'h1d, 5'h1f, 5'h04, 5'h04, 5'h1f, 5'h1f, 5'h08, 5'h10,
        5'h10, 5'h0f, 5'h1f, 5'h04, 5'h0a, 5'h11, 5'h1f, 5'h10,
        5'h10, 5'h1f, 5'h02, 5'h04, 5'h02, 5'h1f, 5'h1f, 5'h02,
        5'h04, 5'h1f, 5'h0e, 5'h11, 5'h11, 5'h0e, 5'h1f, 5'h05,
        5'h05, 5'h02, 5'h0e, 5'h11, 5'h09, 5'h16, 5'h1f, 5'h05,
        5'h0d, 5'h12, 5'h12, 5'h15, 5'h15, 5'h09, 5'h01, 5'h01,
        5'h1f, 5'h01, 5'h01, 5'h0f, 5'h10, 5'h10, 5'h0f, 5'h03,
        5'h0c, 5'h10, 5'h0c, 5'h03, 5'h07, 5'h18, 5'h07, 5'h18,
        5'h07, 5'h1b, 5'h04, 5'h04, 5'h1b, 5'h17, 5'h14, 5'h14,
        5'h0f, 5'h19, 5'h15, 5'h15, 5'h13,
        // colon, period, space, star, percent
        5'h0a, 5'h10, 5'h00,
        5'h02, 5'h04, 5'h08, 5'h04, 5'h02,
        5'h13, 5'h0b, 5'h04, 5'h1a, 5'h19
    };

    // Start of glyph g: digits 0-9, then A-Z; last entry ends Z
    localparam logic [7:0] GLYPH_START [0:36] = '{
        8'h00, 8'h04, 8'h07, 8'h0b, 8'h0f, 8'h13, 8'h17, 8'h1b, 8'h1f, 8'h23,
        8'h27, 8'h2b, 8'h2f, 8'h33, 8'h37, 8'h3a, 8'h3d, 8'h41, 8'h45, 8'h46,
        8'h4a, 8'h4e, 8'h51, 8'h56, 8'h5a, 8'h5e, 8'h62, 8'h66, 8'h6a, 8'h6e,
        8'h73, 8'h77, 8'h7c, 8'h81, 8'h85, 8'h89, 8'h8d
    };

    function automatic pfcr_dec_t char_decode(input logic [7:0] code);
        pfcr_dec_t  d;
        logic [7:0] up;
        logic [5:0] g;
        logic       glyph;
        d     = '0;
        up    = code;
        g     = '0;
        glyph = 1'b0;
        if (code >= CH_LOWER_A && code <= CH_LOWER_Z) begin
            up = code - CASE_FOLD;
        end
        unique case (code)
            CH_COLON:   d = '{hit: 1'b1, start: ADDR_COLON,   len: 3'd1};
            CH_PERIOD:  d = '{hit: 1'b1, start: ADDR_PERIOD,  len: 3'd1};
            CH_STAR:    d = '{hit: 1'b1, start: ADDR_STAR,    len: 3'd5};
            CH_SPACE:   d = '{hit: 1'b1, start: ADDR_SPACE,   len: 3'd1};
            CH_PERCENT: d = '{hit: 1'b1, start: ADDR_PERCENT, len: 3'd5};
            default:
            begin
                if (up >= CH_DIGIT0 && up <= CH_DIGIT9) begin
                    g     = 6'(up - CH_DIGIT0);
                    glyph = 1'b1;
                end else if (up >= CH_UPPER_A && up <= CH_UPPER_Z) begin
                    g     = 6'(up - CH_UPPER_A) + 6'd10;
                    glyph = 1'b1;
                end
                if (glyph) begin
                    d.hit   = 1'b1;
                    d.start = GLYPH_START[g];
                    d.len   = 3'(GLYPH_START[6'(g + 6'd1)] - GLYPH_START[g]);
                end
            end
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/pfcr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfcr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/proportional_font_column_renderer.sv =====
// Top level of the proportional font column renderer.
// Depends on pfcr_pkg (beat types, font table, decoder) and pfcr_ram (glyph store).
//
//  channel   direction  handshake               payload
//  item      in         start & !busy           pfcr_in_t  (column, page row, char code)
//  result    out        result_valid, 1 cycle   pfcr_out_t (one framebuffer column write)
//
// A glyph of N pixel columns gives N+1 result beats, one per cycle, the first one
// following the accept through active_reg and then the result registers; the next
// item is taken on the cycle of the spacing column. Unknown codes give no beats
// and leave busy low.
// After reset the glyph store is loaded with all 154 table entries, with busy high.
// The receiver cannot stall; every beat is shown for exactly one cycle.
module proportional_font_column_renderer
    import pfcr_pkg::*;
#(
    parameter int unsigned SCREEN_WIDTH = 64,
    parameter int unsigned SCREEN_PAGES = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  pfcr_in_t  item,
    output logic      result_valid,
    output pfcr_out_t result
);

    localparam logic [8:0]  WIDTH_LIM = 9'(SCREEN_WIDTH);
    localparam logic [4:0]  PAGES_LIM = 5'(SCREEN_PAGES);
    localparam logic [12:0] ROW_STEP  = 13'(SCREEN_WIDTH);
    localparam logic [7:0]  FILL_LAST = 8'(ROM_DEPTH - 1);

    // glyph store load after reset
    logic       filling_reg, filling_next;
    logic [7:0] fill_cnt_reg, fill_cnt_next;

    // column sequencer
    logic       active_reg, active_next;
    logic [2:0] k_reg, k_next;
    logic [2:0] len_reg, len_next;
    logic [8:0] col_reg, col_next;
    logic [3:0] row_reg, row_next;
    logic [7:0] raddr_reg, raddr_next;

    logic       valid_reg;
    pfcr_out_t  result_reg, result_next;

    pfcr_dec_t          dec;
    logic               accept;
    logic               last;
    logic [RAM_AW-1:0]  raddr;
    logic [GLYPH_W-1:0] glyph_bits;
    logic               on_screen;
    logic [12:0]        lin_addr;

    assign dec    = char_decode(item.char_code);
    assign last   = active_reg && (k_reg == len_reg);
    assign busy   = filling_reg || (active_reg && !last);
    assign accept = start && !busy;
    assign raddr  = accept ? dec.start : raddr_reg;

    pfcr_ram #(
        .WIDTH (GLYPH_W),
        .DEPTH (RAM_DEPTH)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (filling_reg),
        .waddr (fill_cnt_reg),
        .wdata (GLYPH_ROM[fill_cnt_reg]),
        .raddr (raddr),
        .rdata (glyph_bits)
    );

    always_comb
    begin
        filling_next  = filling_reg;
        fill_cnt_next = fill_cnt_reg;
        if (filling_reg) begin
            fill_cnt_next = fill_cnt_reg + 8'd1;
            if (fill_cnt_reg == FILL_LAST) begin
                filling_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        active_next = active_reg;
        k_next      = k_reg;
        len_next    = len_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        raddr_next  = raddr_reg;
        if (active_reg) begin
            k_next     = k_reg + 3'd1;
            col_next   = col_reg + 9'd1;
            raddr_next = raddr_reg + 8'd1;
            if (last) begin
                active_next = 1'b0;
            end
        end
        if (accept && dec.hit) begin
            active_next = 1'b1;
            k_next      = '0;
            len_next    = dec.len;
            col_next    = {1'b0, item.start_column};
            row_next    = item.page_row;
            raddr_next  = dec.start + 8'd1;
        end
    end

    // glyph_bits holds column k, read the cycle before
    always_comb
    begin
        on_screen = (col_reg < WIDTH_LIM) && ({1'b0, row_reg} < PAGES_LIM);
        lin_addr  = ({9'b0, row_reg} * ROW_STEP) + {4'b0, col_reg};
        result_next.buffer_address = on_screen ? lin_addr[8:0] : 9'd0;
        result_next.column_bits    = last ? 8'd0 : {3'b0, glyph_bits};
        result_next.write_enable   = on_screen;
        result_next.next_column    = col_reg + 9'd1;
        result_next.last_column    = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            filling_reg  <= 1'b1;
            fill_cnt_reg <= '0;
            active_reg   <= 1'b0;
            valid_reg    <= 1'b0;
            k_reg        <= '0;
            len_reg      <= '0;
        end else begin
            filling_reg  <= filling_next;
            fill_cnt_reg <= fill_cnt_next;
            active_reg   <= active_next;
            valid_reg    <= active_reg;
            k_reg        <= k_next;
            len_reg      <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg    <= col_next;
        row_reg    <= row_next;
        raddr_reg  <= raddr_next;
        result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

    a_fill_busy: assert property (@(posedge clk) disable iff (!rst_n)
        filling_reg |-> busy)
        else $error("item could be taken while glyph store loads");

    a_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |=> result_valid)
        else $error("column cycle produced no result beat");

    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (k_reg <= len_reg))
        else $error("column counter ran past glyph width");

    a_hit_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && dec.hit) |=> (active_reg && k_reg == 3'd0))
        else $error("known character did not start a glyph");

    a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.write_enable) |-> (result.buffer_address == 9'd0))
        else $error("clipped beat carries an address");

endmodule
